// ===== hw/rtl/sns_pkg.sv =====
package sns_pkg;

  // Field and register widths fixed by the interface.
  localparam int unsigned SIZE_W  = 9;
  localparam int unsigned CNT_W   = 7;
  localparam int unsigned UNITS_W = 17;
  localparam int unsigned OFF_W   = 8;
  localparam int unsigned ACT_W   = 16;
  localparam int unsigned POS_W   = 8;
  localparam int unsigned SLOT_W  = 6;
  localparam int unsigned UIDX_W  = 16;

  // Winner plus signed offset spans -128..382, so ten bits hold it.
  localparam int unsigned SUM_W = 10;
  // Magnitude of that sum.
  localparam int unsigned MAG_W = 9;

  // The remainder takes one bit per step, spread over a few stages.
  localparam int unsigned REM_STAGES     = 3;
  localparam int unsigned BITS_PER_STAGE = 3;

  // Depth of the command queue between front and back.
  localparam int unsigned Q_DEPTH = 2;

  // Configuration port.
  localparam int unsigned APB_AW = 5;
  localparam int unsigned APB_DW = 32;
  localparam int unsigned REG_IW = 3;

  typedef enum logic [REG_IW-1:0] {
    REG_GRID_WIDTH  = 3'd0,
    REG_GRID_HEIGHT = 3'd1,
    REG_WRAP_ENABLE = 3'd2,
    REG_ENTRY_COUNT = 3'd3,
    REG_UNIT_COUNT  = 3'd4
  } reg_idx_t;

  typedef enum logic {
    KIND_LOAD  = 1'b0,
    KIND_APPLY = 1'b1
  } kind_t;

  typedef enum logic {
    BK_IDLE,
    BK_WALK
  } back_state_t;

  // Configuration as stored, before any saturation.
  typedef struct packed {
    logic [SIZE_W-1:0]  grid_width;
    logic [SIZE_W-1:0]  grid_height;
    logic               wrap_enable;
    logic [CNT_W-1:0]   entry_count;
    logic [UNITS_W-1:0] unit_count;
  } cfg_t;

  // One neighborhood table word.
  typedef struct packed {
    logic [OFF_W-1:0] off_x;
    logic [OFF_W-1:0] off_y;
    logic [ACT_W-1:0] act;
  } entry_t;

  // Command passed from the front to the back.
  typedef struct packed {
    kind_t             kind;
    logic [SLOT_W-1:0] slot;
    entry_t            ent;
    logic [POS_W-1:0]  win_x;
    logic [POS_W-1:0]  win_y;
  } cmd_t;

  // One coordinate on its way through the remainder steps.
  typedef struct packed {
    logic             neg;
    logic             drop;
    logic [MAG_W-1:0] mag;
    logic [MAG_W-1:0] rem;
  } lane_t;

  typedef struct packed {
    logic             last;
    logic [ACT_W-1:0] act;
    lane_t            x;
    lane_t            y;
  } mod_stage_t;

  // Set up a coordinate: sign, magnitude and whether it is dropped.
  function automatic lane_t lane_init(input logic [SUM_W-1:0] c,
                                      input logic [SIZE_W-1:0] d,
                                      input logic wrap);
    lane_t l;
    logic  in_range;
    l.neg    = c[SUM_W-1];
    l.mag    = l.neg ? MAG_W'(~c + SUM_W'(1)) : MAG_W'(c);
    in_range = !l.neg && (c < {1'b0, d});
    l.drop   = (d == '0) || (!in_range && !wrap);
    l.rem    = '0;
    return l;
  endfunction

  // One restoring remainder step: bring in the next bit, subtract if it fits.
  function automatic logic [MAG_W-1:0] rem_step(input logic [MAG_W-1:0] rem,
                                                input logic b,
                                                input logic [SIZE_W-1:0] d);
    logic [MAG_W:0] t;
    t = {rem, b};
    if (t >= {1'b0, d}) begin
      t = t - {1'b0, d};
    end
    return t[MAG_W-1:0];
  endfunction

  // The steps of one pipeline stage, taking magnitude bits from the top.
  function automatic lane_t lane_steps(input lane_t l, input logic [SIZE_W-1:0] d);
    lane_t o;
    o = l;
    for (int unsigned k = 0; k < BITS_PER_STAGE; k++) begin
      o.rem = rem_step(o.rem, o.mag[MAG_W-1], d);
      o.mag = o.mag << 1;
    end
    return o;
  endfunction

endpackage

// ===== hw/rtl/sns_ram.sv =====
module sns_ram #(
  parameter int unsigned W = 32,
  parameter int unsigned D = 64,
  localparam int unsigned AW = (D > 1) ? $clog2(D) : 1
) (
  input  logic          clk,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic [W-1:0]  wr_data,
  input  logic          rd_en,
  input  logic [AW-1:0] rd_addr,
  output logic [W-1:0]  rd_data
);

  logic [W-1:0] mem_r [D];
  logic [W-1:0] rd_data_r;

  // One write port and one registered read port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ===== hw/rtl/sns_cfg.sv =====
module sns_cfg import sns_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [APB_AW-1:0] paddr,
  input  logic [APB_DW-1:0] pwdata,
  output logic [APB_DW-1:0] prdata,
  output logic              pready,
  output cfg_t              cfg
);

  logic [SIZE_W-1:0]  grid_width_r, grid_width_nxt;
  logic [SIZE_W-1:0]  grid_height_r, grid_height_nxt;
  logic               wrap_enable_r, wrap_enable_nxt;
  logic [CNT_W-1:0]   entry_count_r, entry_count_nxt;
  logic [UNITS_W-1:0] unit_count_r, unit_count_nxt;
  logic               wr_beat;
  reg_idx_t           reg_sel;

  assign pready  = 1'b1;
  assign wr_beat = psel && penable && pwrite && pready;
  assign reg_sel = reg_idx_t'(paddr[APB_AW-1:2]);

  // Register writes; addresses past the last register are ignored.
  always_comb begin
    grid_width_nxt  = grid_width_r;
    grid_height_nxt = grid_height_r;
    wrap_enable_nxt = wrap_enable_r;
    entry_count_nxt = entry_count_r;
    unit_count_nxt  = unit_count_r;
    if (wr_beat) begin
      case (reg_sel)
        REG_GRID_WIDTH:  grid_width_nxt  = pwdata[SIZE_W-1:0];
        REG_GRID_HEIGHT: grid_height_nxt = pwdata[SIZE_W-1:0];
        REG_WRAP_ENABLE: wrap_enable_nxt = pwdata[0];
        REG_ENTRY_COUNT: entry_count_nxt = pwdata[CNT_W-1:0];
        REG_UNIT_COUNT:  unit_count_nxt  = pwdata[UNITS_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      grid_width_r  <= SIZE_W'(1);
      grid_height_r <= SIZE_W'(1);
      wrap_enable_r <= 1'b0;
      entry_count_r <= '0;
      unit_count_r  <= '0;
    end else begin
      grid_width_r  <= grid_width_nxt;
      grid_height_r <= grid_height_nxt;
      wrap_enable_r <= wrap_enable_nxt;
      entry_count_r <= entry_count_nxt;
      unit_count_r  <= unit_count_nxt;
    end
  end

  // Read back.
  always_comb begin
    case (reg_sel)
      REG_GRID_WIDTH:  prdata = APB_DW'(grid_width_r);
      REG_GRID_HEIGHT: prdata = APB_DW'(grid_height_r);
      REG_WRAP_ENABLE: prdata = APB_DW'(wrap_enable_r);
      REG_ENTRY_COUNT: prdata = APB_DW'(entry_count_r);
      REG_UNIT_COUNT:  prdata = APB_DW'(unit_count_r);
      default:         prdata = '0;
    endcase
  end

  assign cfg.grid_width  = grid_width_r;
  assign cfg.grid_height = grid_height_r;
  assign cfg.wrap_enable = wrap_enable_r;
  assign cfg.entry_count = entry_count_r;
  assign cfg.unit_count  = unit_count_r;

endmodule

// ===== hw/rtl/sns_front.sv =====
module sns_front import sns_pkg::*; #(
  parameter int unsigned MAX_ENTRIES = 64
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic                    in_kind,
  input  logic [SLOT_W-1:0]       in_entry_slot,
  input  logic signed [OFF_W-1:0] in_offset_x,
  input  logic signed [OFF_W-1:0] in_offset_y,
  input  logic signed [ACT_W-1:0] in_entry_act,
  input  logic [POS_W-1:0]        in_winner_x,
  input  logic [POS_W-1:0]        in_winner_y,
  input  logic                    cmd_pop,
  output logic                    cmd_valid,
  output cmd_t                    cmd
);

  localparam int unsigned QPW = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
  localparam int unsigned QCW = $clog2(Q_DEPTH + 1);

  cmd_t           q_r [Q_DEPTH];
  logic [QPW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QCW-1:0] cnt_r, cnt_nxt;
  logic           accept;
  logic           slot_ok;
  logic           push;
  cmd_t           cmd_in;

  assign in_ready = (cnt_r != QCW'(Q_DEPTH));
  assign accept   = in_valid && in_ready;

  // Classify the beat: loads to a slot outside the table are dropped here.
  assign slot_ok = (CNT_W'(in_entry_slot) < CNT_W'(MAX_ENTRIES));
  assign push    = accept && ((kind_t'(in_kind) == KIND_APPLY) || slot_ok);

  assign cmd_in.kind      = kind_t'(in_kind);
  assign cmd_in.slot      = in_entry_slot;
  assign cmd_in.ent.off_x = in_offset_x;
  assign cmd_in.ent.off_y = in_offset_y;
  assign cmd_in.ent.act   = in_entry_act;
  assign cmd_in.win_x     = in_winner_x;
  assign cmd_in.win_y     = in_winner_y;

  // Queue pointers and fill count.
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == QPW'(Q_DEPTH - 1)) ? '0 : wr_ptr_r + QPW'(1);
    end
    if (cmd_pop) begin
      rd_ptr_nxt = (rd_ptr_r == QPW'(Q_DEPTH - 1)) ? '0 : rd_ptr_r + QPW'(1);
    end
    if (push && !cmd_pop) begin
      cnt_nxt = cnt_r + QCW'(1);
    end else if (!push && cmd_pop) begin
      cnt_nxt = cnt_r - QCW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // Queue storage.
  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wr_ptr_r] <= cmd_in;
    end
  end

  assign cmd_valid = (cnt_r != '0);
  assign cmd       = q_r[rd_ptr_r];

`ifndef NO_ASSERTIONS
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= QCW'(Q_DEPTH))
    else $error("command queue count beyond its depth");

  a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    cmd_pop |-> (cnt_r != '0))
    else $error("back end popped an empty command queue");
`endif

endmodule

// ===== hw/rtl/sns_back.sv =====
module sns_back import sns_pkg::*; #(
  parameter int unsigned MAX_ENTRIES = 64,
  parameter int unsigned MAX_DIM     = 256
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  cfg_t                    cfg,
  input  logic                    cmd_valid,
  input  cmd_t                    cmd,
  output logic                    cmd_pop,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic [UIDX_W-1:0]       out_unit_index,
  output logic signed [ACT_W-1:0] out_act_value,
  output logic                    out_hit,
  output logic                    out_last
);

  localparam int unsigned AW    = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int unsigned CW    = $clog2(MAX_DIM);
  localparam int unsigned WW    = $clog2(MAX_DIM + 1);
  localparam int unsigned IW    = $clog2(MAX_DIM * MAX_DIM);
  localparam int unsigned ENT_W = $bits(entry_t);

  // Saturated configuration.
  logic [CNT_W-1:0]   n_eff;
  logic [UNITS_W-1:0] units_eff;
  logic [SIZE_W-1:0]  dx, dy;
  logic [WW-1:0]      w_eff;

  assign n_eff     = (cfg.entry_count > CNT_W'(MAX_ENTRIES)) ? CNT_W'(MAX_ENTRIES)
                                                              : cfg.entry_count;
  assign units_eff = (cfg.unit_count > UNITS_W'(MAX_DIM * MAX_DIM))
                     ? UNITS_W'(MAX_DIM * MAX_DIM) : cfg.unit_count;
  assign dx        = (cfg.grid_width > SIZE_W'(MAX_DIM)) ? SIZE_W'(MAX_DIM)
                                                          : cfg.grid_width;
  assign dy        = (cfg.grid_height > SIZE_W'(MAX_DIM)) ? SIZE_W'(MAX_DIM)
                                                           : cfg.grid_height;
  assign w_eff     = WW'(dx);

  // The whole pipeline moves when the output register is free or drained.
  logic adv;
  logic out_valid_r;

  assign adv = !out_valid_r || out_ready;

  // Sequencer: takes commands, writes loads, walks the table for applies.
  back_state_t      state_r, state_nxt;
  logic [AW-1:0]    idx_r, idx_nxt;
  logic [POS_W-1:0] win_x_r, win_x_nxt;
  logic [POS_W-1:0] win_y_r, win_y_nxt;
  logic             ram_we;
  logic             issue;
  logic             last_issue;
  entry_t           ent_rd;
  logic [ENT_W-1:0] ent_rd_raw;

  assign last_issue = (CNT_W'(idx_r) + CNT_W'(1) == n_eff);

  always_comb begin
    state_nxt = state_r;
    idx_nxt   = idx_r;
    win_x_nxt = win_x_r;
    win_y_nxt = win_y_r;
    cmd_pop   = 1'b0;
    ram_we    = 1'b0;
    issue     = 1'b0;
    case (state_r)
      BK_IDLE: begin
        if (cmd_valid) begin
          cmd_pop = 1'b1;
          case (cmd.kind)
            KIND_LOAD: begin
              ram_we = 1'b1;
            end
            KIND_APPLY: begin
              if (n_eff != '0) begin
                state_nxt = BK_WALK;
                idx_nxt   = '0;
                win_x_nxt = cmd.win_x;
                win_y_nxt = cmd.win_y;
              end
            end
            default: ;
          endcase
        end
      end
      BK_WALK: begin
        if (adv) begin
          issue = 1'b1;
          if (last_issue) begin
            state_nxt = BK_IDLE;
          end else begin
            idx_nxt = idx_r + AW'(1);
          end
        end
      end
      default: begin
        state_nxt = BK_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= BK_IDLE;
      idx_r   <= '0;
    end else begin
      state_r <= state_nxt;
      idx_r   <= idx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    win_x_r <= win_x_nxt;
    win_y_r <= win_y_nxt;
  end

  // Neighborhood table.
  sns_ram #(
    .W (ENT_W),
    .D (MAX_ENTRIES)
  ) u_table (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (cmd.slot[AW-1:0]),
    .wr_data (cmd.ent),
    .rd_en   (issue),
    .rd_addr (idx_r),
    .rd_data (ent_rd_raw)
  );

  assign ent_rd = entry_t'(ent_rd_raw);

  // Stage 0 travels alongside the table read.
  logic             s0_vld_r;
  logic             s0_last_r;
  logic [POS_W-1:0] s0_wx_r, s0_wy_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_vld_r <= 1'b0;
    end else if (adv) begin
      s0_vld_r <= issue;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s0_last_r <= last_issue;
      s0_wx_r   <= win_x_r;
      s0_wy_r   <= win_y_r;
    end
  end

  // Add offsets to the winner and set up both coordinates.
  logic [SUM_W-1:0] cx, cy;

  assign cx = {{(SUM_W - POS_W){1'b0}}, s0_wx_r}
            + {{(SUM_W - OFF_W){ent_rd.off_x[OFF_W-1]}}, ent_rd.off_x};
  assign cy = {{(SUM_W - POS_W){1'b0}}, s0_wy_r}
            + {{(SUM_W - OFF_W){ent_rd.off_y[OFF_W-1]}}, ent_rd.off_y};

  // Remainder stages: stage 0 is the set-up, each later one takes a few bits.
  mod_stage_t            st_r   [REM_STAGES+1];
  mod_stage_t            st_nxt [REM_STAGES+1];
  logic [REM_STAGES:0]   st_vld_r;

  always_comb begin
    st_nxt[0].last = s0_last_r;
    st_nxt[0].act  = ent_rd.act;
    st_nxt[0].x    = lane_init(cx, dx, cfg.wrap_enable);
    st_nxt[0].y    = lane_init(cy, dy, cfg.wrap_enable);
    for (int unsigned s = 0; s < REM_STAGES; s++) begin
      st_nxt[s+1].last = st_r[s].last;
      st_nxt[s+1].act  = st_r[s].act;
      st_nxt[s+1].x    = lane_steps(st_r[s].x, dx);
      st_nxt[s+1].y    = lane_steps(st_r[s].y, dy);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_vld_r <= '0;
    end else if (adv) begin
      st_vld_r <= {st_vld_r[REM_STAGES-1:0], s0_vld_r};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      st_r <= st_nxt;
    end
  end

  // Turn a negative remainder into a true modulo and pick the coordinate.
  mod_stage_t        st_done;
  logic [SIZE_W-1:0] fx, fy;
  logic              p_vld_r, p_last_r, p_ok_r;
  logic [ACT_W-1:0]  p_act_r;
  logic [CW-1:0]     p_x_r, p_y_r;

  assign st_done = st_r[REM_STAGES];
  assign fx = (st_done.x.neg && (st_done.x.rem != '0)) ? dx - st_done.x.rem
                                                       : st_done.x.rem;
  assign fy = (st_done.y.neg && (st_done.y.rem != '0)) ? dy - st_done.y.rem
                                                       : st_done.y.rem;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p_vld_r <= 1'b0;
    end else if (adv) begin
      p_vld_r <= st_vld_r[REM_STAGES];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      p_last_r <= st_done.last;
      p_act_r  <= st_done.act;
      p_ok_r   <= !st_done.x.drop && !st_done.y.drop;
      p_x_r    <= fx[CW-1:0];
      p_y_r    <= fy[CW-1:0];
    end
  end

  // Linear index: row times width plus column.
  logic [CW+WW-1:0] prod;
  logic [IW-1:0]    lin_idx;
  logic             m_vld_r, m_last_r, m_ok_r;
  logic [ACT_W-1:0] m_act_r;
  logic [IW-1:0]    m_idx_r;

  assign prod    = p_y_r * w_eff;
  assign lin_idx = IW'(prod) + IW'(p_x_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      m_vld_r <= 1'b0;
    end else if (adv) begin
      m_vld_r <= p_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      m_last_r <= p_last_r;
      m_act_r  <= p_act_r;
      m_ok_r   <= p_ok_r;
      m_idx_r  <= lin_idx;
    end
  end

  // Unit count check and output register.
  logic              hit;
  logic [UIDX_W-1:0] out_idx_r;
  logic [ACT_W-1:0]  out_act_r;
  logic              out_hit_r, out_last_r;

  assign hit = m_ok_r && (UNITS_W'(m_idx_r) < units_eff);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= m_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_idx_r  <= hit ? UIDX_W'(m_idx_r) : '0;
      out_act_r  <= hit ? m_act_r : '0;
      out_hit_r  <= hit;
      out_last_r <= m_last_r;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_unit_index = out_idx_r;
  assign out_act_value  = out_act_r;
  assign out_hit        = out_hit_r;
  assign out_last       = out_last_r;

`ifndef NO_ASSERTIONS
  a_walk_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == BK_WALK) |-> (CNT_W'(idx_r) < n_eff))
    else $error("table walk index past the entry count");

  a_walk_ends: assert property (@(posedge clk) disable iff (!rst_n)
    (issue && last_issue) |=> (state_r == BK_IDLE))
    else $error("walk did not end after its final entry");

  a_stall_freezes: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_ready) |=> (m_vld_r == $past(m_vld_r)
                                    && st_vld_r == $past(st_vld_r)))
    else $error("pipeline moved while the output was stalled");
`endif

endmodule

// ===== hw/rtl/som_neighborhood_stamp_unit.sv =====
// Channel   Direction  Handshake           Beat contents
// in_*      input      in_valid/in_ready   kind, entry_slot, offsets, activation, winner
// out_*     output     out_valid/out_ready unit_index, act_value, hit, last
// config    input      psel/penable/pready five registers at byte addresses 0,4,8,12,16
//
// A load beat is written to the table when the back end takes it; an apply beat holds
// the back end while it walks min(entry_count, MAX_ENTRIES) entries, one table read per
// cycle through one port while the output is not stalled. Each read then passes the
// set-up, remainder, modulo, index and output registers. Reset (rst_n low, synchronous)
// sets grid width and height to 1 and clears other configuration and control; the table
// is undefined until loaded. A stalled output freezes the back-end pipeline, while the
// front still takes beats until its two-entry command queue is full.
module som_neighborhood_stamp_unit import sns_pkg::*; #(
  parameter int unsigned MAX_ENTRIES = 64,
  parameter int unsigned MAX_DIM     = 256
) (
  input  logic                    clk,
  input  logic                    rst_n,
  // Input channel
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic                    in_kind,
  input  logic [SLOT_W-1:0]       in_entry_slot,
  input  logic signed [OFF_W-1:0] in_offset_x,
  input  logic signed [OFF_W-1:0] in_offset_y,
  input  logic signed [ACT_W-1:0] in_entry_act,
  input  logic [POS_W-1:0]        in_winner_x,
  input  logic [POS_W-1:0]        in_winner_y,
  // Result channel
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic [UIDX_W-1:0]       out_unit_index,
  output logic signed [ACT_W-1:0] out_act_value,
  output logic                    out_hit,
  output logic                    out_last,
  // Configuration port
  input  logic                    psel,
  input  logic                    penable,
  input  logic                    pwrite,
  input  logic [APB_AW-1:0]       paddr,
  input  logic [APB_DW-1:0]       pwdata,
  output logic [APB_DW-1:0]       prdata,
  output logic                    pready
);

  cfg_t cfg;
  logic cmd_valid;
  logic cmd_pop;
  cmd_t cmd;

  // Configuration registers.
  sns_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // Front end: accepts and classifies beats into the command queue.
  sns_front #(
    .MAX_ENTRIES (MAX_ENTRIES)
  ) u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_kind       (in_kind),
    .in_entry_slot (in_entry_slot),
    .in_offset_x   (in_offset_x),
    .in_offset_y   (in_offset_y),
    .in_entry_act  (in_entry_act),
    .in_winner_x   (in_winner_x),
    .in_winner_y   (in_winner_y),
    .cmd_pop       (cmd_pop),
    .cmd_valid     (cmd_valid),
    .cmd           (cmd)
  );

  // Back end: table, walk sequencer and coordinate pipeline.
  sns_back #(
    .MAX_ENTRIES (MAX_ENTRIES),
    .MAX_DIM     (MAX_DIM)
  ) u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg            (cfg),
    .cmd_valid      (cmd_valid),
    .cmd            (cmd),
    .cmd_pop        (cmd_pop),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_unit_index (out_unit_index),
    .out_act_value  (out_act_value),
    .out_hit        (out_hit),
    .out_last       (out_last)
  );

endmodule

// ===== sim/neighborhood_stamp_checker.sv =====
`timescale 1ns / 1ps

// Watches the load/apply channel, the result channel and the register port,
// predicts every result beat and compares it with what the block sends.
module neighborhood_stamp_checker import sns_pkg::*; (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  input  logic                    in_ready,
  input  logic                    in_kind,
  input  logic [SLOT_W-1:0]       in_entry_slot,
  input  logic signed [OFF_W-1:0] in_offset_x,
  input  logic signed [OFF_W-1:0] in_offset_y,
  input  logic signed [ACT_W-1:0] in_entry_act,
  input  logic [POS_W-1:0]        in_winner_x,
  input  logic [POS_W-1:0]        in_winner_y,
  input  logic                    out_valid,
  input  logic                    out_ready,
  input  logic [UIDX_W-1:0]       out_unit_index,
  input  logic signed [ACT_W-1:0] out_act_value,
  input  logic                    out_hit,
  input  logic                    out_last,
  input  logic                    psel,
  input  logic                    penable,
  input  logic                    pwrite,
  input  logic                    pready,
  input  logic [APB_AW-1:0]       paddr,
  input  logic [APB_DW-1:0]       pwdata,
  output int unsigned             stamps_pending,
  output int unsigned             mismatch_count
);

  localparam int TABLE_DEPTH = 64;
  localparam int DIM_CAP     = 256;
  localparam int UNIT_CAP    = DIM_CAP * DIM_CAP;

  // One predicted result beat.
  typedef struct packed {
    logic [UIDX_W-1:0] unit_index;
    logic [ACT_W-1:0]  act_value;
    logic              hit;
    logic              last;
  } stamp_t;

  cfg_t        shadow_cfg;
  entry_t      shadow_table [TABLE_DEPTH];
  stamp_t      expected_stamps [$];
  int unsigned errors = 0;

  task automatic report_mismatch(input string what);
    $display("%0t ns: stamp check: %s", $time, what);
    errors++;
  endtask

  // Place one coordinate on an axis of the given size; -1 means dropped.
  // Wrapping is a true modulo, so negative sums land in 0..d-1 for the size d capped at 256.
  function automatic int place_coord(input int c, input logic [SIZE_W-1:0] size,
                                     input logic wrap);
    int d;
    int r;
    if (size == 0) return -1;
    d = (size > DIM_CAP) ? DIM_CAP : int'(size);
    if (c >= 0 && c < d) return c;
    if (!wrap) return -1;
    r = c % d;
    if (r < 0) r += d;
    return r;
  endfunction

  // Queue one result per table entry in use for a winner at (wx, wy).
  function automatic void predict_stamps(input logic [POS_W-1:0] wx,
                                         input logic [POS_W-1:0] wy);
    int     n;
    int     units;
    int     w;
    int     sx;
    int     sy;
    int     idx;
    logic   hit;
    stamp_t s;
    n     = (shadow_cfg.entry_count > TABLE_DEPTH) ? TABLE_DEPTH : int'(shadow_cfg.entry_count);
    units = (shadow_cfg.unit_count > UNIT_CAP) ? UNIT_CAP : int'(shadow_cfg.unit_count);
    w     = (shadow_cfg.grid_width > DIM_CAP) ? DIM_CAP : int'(shadow_cfg.grid_width);
    for (int i = 0; i < n; i++) begin
      sx  = place_coord(int'(wx) + int'($signed(shadow_table[i].off_x)),
                        shadow_cfg.grid_width, shadow_cfg.wrap_enable);
      sy  = place_coord(int'(wy) + int'($signed(shadow_table[i].off_y)),
                        shadow_cfg.grid_height, shadow_cfg.wrap_enable);
      hit = 1'b0;
      idx = 0;
      if (sx >= 0 && sy >= 0) begin
        idx = sy * w + sx;
        hit = (idx < units);
      end
      s.unit_index = hit ? UIDX_W'(idx) : '0;
      s.act_value  = hit ? shadow_table[i].act : '0;
      s.hit        = hit;
      s.last       = (i == n - 1);
      expected_stamps.push_back(s);
    end
  endfunction

  // Track register writes and table loads, predict on applies, check results.
  always @(posedge clk) begin
    stamp_t want;
    if (!rst_n) begin
      shadow_cfg             = '0;
      shadow_cfg.grid_width  = SIZE_W'(1);
      shadow_cfg.grid_height = SIZE_W'(1);
      expected_stamps.delete();
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (reg_idx_t'(paddr[APB_AW-1:2]))
          REG_GRID_WIDTH:  shadow_cfg.grid_width  = pwdata[SIZE_W-1:0];
          REG_GRID_HEIGHT: shadow_cfg.grid_height = pwdata[SIZE_W-1:0];
          REG_WRAP_ENABLE: shadow_cfg.wrap_enable = pwdata[0];
          REG_ENTRY_COUNT: shadow_cfg.entry_count = pwdata[CNT_W-1:0];
          REG_UNIT_COUNT:  shadow_cfg.unit_count  = pwdata[UNITS_W-1:0];
          default: ;
        endcase
      end

      if (in_valid && in_ready) begin
        if (kind_t'(in_kind) == KIND_LOAD) begin
          shadow_table[in_entry_slot].off_x = in_offset_x;
          shadow_table[in_entry_slot].off_y = in_offset_y;
          shadow_table[in_entry_slot].act   = in_entry_act;
        end else begin
          predict_stamps(in_winner_x, in_winner_y);
        end
      end

      if (out_valid && out_ready) begin
        if (expected_stamps.size() == 0) begin
          report_mismatch($sformatf("result beat with none expected (index %0d, hit %0b)",
                                    out_unit_index, out_hit));
        end else begin
          want = expected_stamps.pop_front();
          if (out_unit_index !== want.unit_index)
            report_mismatch($sformatf("unit_index got %0d expected %0d",
                                      out_unit_index, want.unit_index));
          if (out_act_value !== want.act_value)
            report_mismatch($sformatf("act_value got %0d expected %0d",
                                      out_act_value, $signed(want.act_value)));
          if (out_hit !== want.hit)
            report_mismatch($sformatf("hit got %b expected %b", out_hit, want.hit));
          if (out_last !== want.last)
            report_mismatch($sformatf("last got %b expected %b", out_last, want.last));
        end
      end
    end
    stamps_pending <= expected_stamps.size();
    mismatch_count <= errors;
  end

endmodule

// ===== sim/testbench.sv =====
`timescale 1ns / 1ps

module testbench;
  import sns_pkg::*;

  localparam int unsigned IDLE_LIMIT      = 5000;
  localparam int unsigned HOLD_OFF_CYCLES = 300;
  localparam int unsigned SETTLE_CYCLES   = 30;
  localparam int unsigned TARGET_BEATS    = 300;

  logic                    clk = 1'b0;
  logic                    rst_n;
  logic                    in_valid;
  logic                    in_ready;
  logic                    in_kind;
  logic [SLOT_W-1:0]       in_entry_slot;
  logic signed [OFF_W-1:0] in_offset_x;
  logic signed [OFF_W-1:0] in_offset_y;
  logic signed [ACT_W-1:0] in_entry_act;
  logic [POS_W-1:0]        in_winner_x;
  logic [POS_W-1:0]        in_winner_y;
  logic                    out_valid;
  logic                    out_ready;
  logic [UIDX_W-1:0]       out_unit_index;
  logic signed [ACT_W-1:0] out_act_value;
  logic                    out_hit;
  logic                    out_last;
  logic                    psel;
  logic                    penable;
  logic                    pwrite;
  logic [APB_AW-1:0]       paddr;
  logic [APB_DW-1:0]       pwdata;
  logic [APB_DW-1:0]       prdata;
  logic                    pready;

  int unsigned stamps_pending;
  int unsigned mismatch_count;

  int unsigned       beats_sent    = 0;
  bit                steady_sender = 1'b0;
  bit                stall_armed   = 1'b0;
  bit                stall_done    = 1'b0;
  logic [SIZE_W-1:0] cur_w;
  logic [SIZE_W-1:0] cur_h;

  always #5 clk = ~clk;

  som_neighborhood_stamp_unit u_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_kind(in_kind),
    .in_entry_slot(in_entry_slot), .in_offset_x(in_offset_x), .in_offset_y(in_offset_y),
    .in_entry_act(in_entry_act), .in_winner_x(in_winner_x), .in_winner_y(in_winner_y),
    .out_valid(out_valid), .out_ready(out_ready), .out_unit_index(out_unit_index),
    .out_act_value(out_act_value), .out_hit(out_hit), .out_last(out_last),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  neighborhood_stamp_checker u_checker (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_kind(in_kind),
    .in_entry_slot(in_entry_slot), .in_offset_x(in_offset_x), .in_offset_y(in_offset_y),
    .in_entry_act(in_entry_act), .in_winner_x(in_winner_x), .in_winner_y(in_winner_y),
    .out_valid(out_valid), .out_ready(out_ready), .out_unit_index(out_unit_index),
    .out_act_value(out_act_value), .out_hit(out_hit), .out_last(out_last),
    .psel(psel), .penable(penable), .pwrite(pwrite), .pready(pready),
    .paddr(paddr), .pwdata(pwdata),
    .stamps_pending(stamps_pending), .mismatch_count(mismatch_count)
  );

  // Idle gap: mostly none, often short, now and then long.
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Grid size, including zero and sizes past the saturation point.
  function automatic logic [SIZE_W-1:0] pick_dim();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return SIZE_W'(1);
      2: return SIZE_W'(2);
      3: return SIZE_W'(256);
      4: return SIZE_W'($urandom_range(257, 511));
      default: return SIZE_W'($urandom_range(1, 32));
    endcase
  endfunction

  function automatic logic [UNITS_W-1:0] pick_units(input logic [SIZE_W-1:0] w,
                                                    input logic [SIZE_W-1:0] h);
    int unsigned cap;
    cap = ((w > 256) ? 256 : int'(w)) * ((h > 256) ? 256 : int'(h));
    case ($urandom_range(0, 5))
      0: return '0;
      1: return UNITS_W'(cap);
      2: return UNITS_W'(65536);
      3: return UNITS_W'(131071);
      4: return UNITS_W'($urandom_range(0, 131071));
      default: return UNITS_W'((cap == 0) ? $urandom_range(0, 300) : $urandom_range(0, cap));
    endcase
  endfunction

  // Entries in use: mostly a handful, sometimes the full table or beyond it.
  function automatic logic [CNT_W-1:0] pick_count();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return CNT_W'(64);
      2: return CNT_W'($urandom_range(65, 127));
      default: return CNT_W'($urandom_range(1, 12));
    endcase
  endfunction

  // Offsets are either anywhere in range or close to the winner.
  function automatic logic [OFF_W-1:0] rand_off();
    if ($urandom_range(0, 1) == 0) return OFF_W'($urandom);
    return OFF_W'(int'($urandom_range(0, 8)) - 4);
  endfunction

  // Winner coordinate, half the time inside the current grid.
  function automatic logic [POS_W-1:0] pick_pos(input logic [SIZE_W-1:0] size);
    if (size != 0 && $urandom_range(0, 1) == 0)
      return POS_W'($urandom_range(0, ((size > 256) ? 256 : int'(size)) - 1));
    return POS_W'($urandom);
  endfunction

  // Offer one beat and hold it until the block takes it.
  task automatic send_beat(input kind_t kind, input logic [SLOT_W-1:0] slot,
                           input logic [OFF_W-1:0] ox, input logic [OFF_W-1:0] oy,
                           input logic [ACT_W-1:0] act, input logic [POS_W-1:0] wx,
                           input logic [POS_W-1:0] wy);
    int unsigned gap;
    gap = steady_sender ? 0 : pick_gap();
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_kind       <= kind;
    in_entry_slot <= slot;
    in_offset_x   <= ox;
    in_offset_y   <= oy;
    in_entry_act  <= act;
    in_winner_x   <= wx;
    in_winner_y   <= wy;
    do @(posedge clk); while (!(in_valid && in_ready));
    beats_sent++;
  endtask

  task automatic send_load(input logic [SLOT_W-1:0] slot, input logic [OFF_W-1:0] ox,
                           input logic [OFF_W-1:0] oy, input logic [ACT_W-1:0] act);
    send_beat(KIND_LOAD, slot, ox, oy, act, POS_W'($urandom), POS_W'($urandom));
  endtask

  task automatic send_apply(input logic [POS_W-1:0] wx, input logic [POS_W-1:0] wy);
    send_beat(KIND_APPLY, SLOT_W'($urandom), OFF_W'($urandom), OFF_W'($urandom),
              ACT_W'($urandom), wx, wy);
  endtask

  // Drain: every expected result back, then a settle wait for result-free beats.
  task automatic wait_idle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (stamps_pending != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Setup phase, access phase until pready, then the bus is left idle.
  task automatic write_reg(input reg_idx_t which, input logic [APB_DW-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {which, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  task automatic setup_grid(input logic [SIZE_W-1:0] w, input logic [SIZE_W-1:0] h,
                            input logic wrap, input logic [CNT_W-1:0] count,
                            input logic [UNITS_W-1:0] units);
    wait_idle();
    write_reg(REG_GRID_WIDTH, APB_DW'(w));
    write_reg(REG_GRID_HEIGHT, APB_DW'(h));
    write_reg(REG_WRAP_ENABLE, APB_DW'(wrap));
    write_reg(REG_ENTRY_COUNT, APB_DW'(count));
    write_reg(REG_UNIT_COUNT, APB_DW'(units));
    cur_w = w;
    cur_h = h;
  endtask

  // Stimulus and verdict.
  initial begin
    logic [SIZE_W-1:0] w;
    logic [SIZE_W-1:0] h;
    logic [CNT_W-1:0]  count;
    int unsigned       phase;
    int unsigned       n_beats;
    in_valid      <= 1'b0;
    in_kind       <= KIND_LOAD;
    in_entry_slot <= '0;
    in_offset_x   <= '0;
    in_offset_y   <= '0;
    in_entry_act  <= '0;
    in_winner_x   <= '0;
    in_winner_y   <= '0;
    psel          <= 1'b0;
    penable       <= 1'b0;
    pwrite        <= 1'b0;
    paddr         <= '0;
    pwdata        <= '0;
    rst_n         <= 1'b0;
    cur_w          = SIZE_W'(1);
    cur_h          = SIZE_W'(1);
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Entry count zero after reset: an apply gives no result.
    send_apply(POS_W'(7), POS_W'(9));

    // Table entries at the extremes of offset and activation.
    send_load(SLOT_W'(0), OFF_W'(0), OFF_W'(0), ACT_W'(16'h1000));
    send_load(SLOT_W'(1), OFF_W'(-128), OFF_W'(-128), ACT_W'(16'h8000));
    send_load(SLOT_W'(2), OFF_W'(127), OFF_W'(127), ACT_W'(16'h7FFF));
    send_load(SLOT_W'(3), OFF_W'(-1), OFF_W'(1), ACT_W'(16'hFFFF));
    send_load(SLOT_W'(4), OFF_W'(1), OFF_W'(-1), ACT_W'(16'h0001));
    send_load(SLOT_W'(5), OFF_W'(-128), OFF_W'(127), ACT_W'(16'h8001));
    send_load(SLOT_W'(6), OFF_W'(127), OFF_W'(-128), ACT_W'(16'h0000));
    send_load(SLOT_W'(7), OFF_W'(5), OFF_W'(0), ACT_W'(16'h7000));

    // Clipped grid with a unit count that cuts off the bottom rows.
    setup_grid(SIZE_W'(16), SIZE_W'(8), 1'b0, CNT_W'(8), UNITS_W'(100));
    send_apply(POS_W'(0), POS_W'(0));
    send_apply(POS_W'(255), POS_W'(255));
    send_apply(POS_W'(8), POS_W'(4));

    // Same grid wrapped: negative sums and a winner outside the grid.
    setup_grid(SIZE_W'(16), SIZE_W'(8), 1'b1, CNT_W'(8), UNITS_W'(128));
    send_apply(POS_W'(0), POS_W'(0));
    send_apply(POS_W'(255), POS_W'(255));
    send_apply(POS_W'(15), POS_W'(7));

    // Zero width drops every entry.
    setup_grid(SIZE_W'(0), SIZE_W'(256), 1'b1, CNT_W'(8), UNITS_W'(65536));
    send_apply(POS_W'(3), POS_W'(3));

    // Full-size grid, top corner index.
    setup_grid(SIZE_W'(256), SIZE_W'(256), 1'b0, CNT_W'(8), UNITS_W'(65536));
    send_apply(POS_W'(255), POS_W'(255));
    send_apply(POS_W'(0), POS_W'(128));

    // Oversized grid and unit count saturate.
    setup_grid(SIZE_W'(511), SIZE_W'(300), 1'b1, CNT_W'(1), UNITS_W'(131071));
    send_apply(POS_W'(200), POS_W'(10));

    // Fill the whole table, then walk all of it with an oversized entry count.
    setup_grid(SIZE_W'(256), SIZE_W'(256), 1'b1, CNT_W'(127), UNITS_W'(131071));
    for (int k = 0; k < 64; k++) begin
      send_load(SLOT_W'(k), rand_off(), rand_off(), ACT_W'($urandom));
    end
    repeat (4) send_apply(POS_W'($urandom), POS_W'($urandom));

    // Random phases, each under its own register setting.
    phase = 0;
    while (beats_sent < TARGET_BEATS) begin
      w     = pick_dim();
      h     = pick_dim();
      count = (phase == 1) ? CNT_W'(12) : pick_count();
      setup_grid(w, h, 1'($urandom_range(0, 1)), count, pick_units(w, h));
      steady_sender = (phase == 1) || ($urandom_range(0, 3) == 0);
      // One phase holds off the receiver while applies keep coming.
      if (phase == 1) stall_armed = 1'b1;
      n_beats = $urandom_range(20, 40);
      repeat (n_beats) begin
        if (phase != 1 && $urandom_range(0, 99) < 35)
          send_load(SLOT_W'($urandom), rand_off(), rand_off(), ACT_W'($urandom));
        else
          send_apply(pick_pos(cur_w), pick_pos(cur_h));
      end
      phase++;
    end

    wait_idle();
    if (mismatch_count == 0 && stamps_pending == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end

  // Result side: random stalls, ready runs of varying length, one long hold-off.
  initial begin
    int unsigned pause;
    int unsigned run;
    out_ready <= 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (stall_armed && !stall_done) begin
        out_ready <= 1'b0;
        repeat (HOLD_OFF_CYCLES) @(posedge clk);
        stall_done = 1'b1;
      end else begin
        pause = pick_gap();
        if (pause != 0) begin
          out_ready <= 1'b0;
          repeat (pause) @(posedge clk);
        end
        out_ready <= 1'b1;
        run = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 80) : $urandom_range(1, 6);
        repeat (run) @(posedge clk);
      end
    end
  end

  // Watchdog: too long without any beat or register access ends the run.
  initial begin
    int unsigned quiet;
    quiet = 0;
    while (quiet < IDLE_LIMIT) begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready) || (psel && penable))
        quiet = 0;
      else
        quiet++;
    end
    $display("Test completed with failures");
    $finish;
  end

endmodule

// ===== som_neighborhood_stamp_unit.f =====
hw/rtl/sns_pkg.sv
hw/rtl/sns_ram.sv
hw/rtl/sns_cfg.sv
hw/rtl/sns_front.sv
hw/rtl/sns_back.sv
hw/rtl/som_neighborhood_stamp_unit.sv
sim/neighborhood_stamp_checker.sv
sim/testbench.sv
